// ----- src/qha_pkg.sv -----
// ============================================================================
// qha_pkg
// Shared types, widths and the arctangent table for the heading angle block.
// ============================================================================
package qha_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 16;
    localparam int ACC_FRAC        = 16;
    localparam int TABLE_LEN       = 24;
    localparam int OUT_WIDTH       = 17;

    localparam int MAG_W   = COORD_WIDTH + 1;
    localparam int CORD_W  = COORD_WIDTH + 3;
    localparam int Z_W     = 25;
    localparam int RND_SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int SUM_W   = OUT_WIDTH + 1;

    localparam logic [Z_W-1:0]       RND_HALF = Z_W'(1) << (RND_SH - 1);
    localparam logic [OUT_WIDTH-1:0] LIMIT    = OUT_WIDTH'((360 << ANGLE_FRAC_BITS) - 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [MAG_W-1:0]       t_mag;
    typedef logic signed [CORD_W-1:0]      t_cord;
    typedef logic signed [Z_W-1:0]         t_angle;
    typedef logic        [OUT_WIDTH-1:0]   t_heading;

    typedef enum logic [1:0] {
        QUAD_BASE_0   = 2'd0,
        QUAD_BASE_90  = 2'd1,
        QUAD_BASE_180 = 2'd2,
        QUAD_BASE_270 = 2'd3
    } t_quad;

    typedef struct packed {
        logic  axis;
        t_quad quad;
    } t_tag;

    localparam t_angle ATAN_DEG_Q16 [TABLE_LEN] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    function automatic logic [OUT_WIDTH-1:0] quad_base(input t_quad q);
        logic [OUT_WIDTH-1:0] b;
        b = '0;
        unique case (q)
            QUAD_BASE_0:   b = '0;
            QUAD_BASE_90:  b = OUT_WIDTH'(90  << ANGLE_FRAC_BITS);
            QUAD_BASE_180: b = OUT_WIDTH'(180 << ANGLE_FRAC_BITS);
            QUAD_BASE_270: b = OUT_WIDTH'(270 << ANGLE_FRAC_BITS);
            default:       b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- src/qha_if.sv -----
// ============================================================================
// qha_vec_if / qha_head_if
// Valid/ready channels for input vectors and heading results.
// ============================================================================
interface qha_vec_if;
    logic             valid;
    logic             ready;
    qha_pkg::t_coord  vec_x;
    qha_pkg::t_coord  vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface qha_head_if;
    logic               valid;
    logic               ready;
    qha_pkg::t_heading  heading_deg;

    modport source (output valid, output heading_deg, input ready);
    modport sink   (input valid, input heading_deg, output ready);
endinterface

// ----- src/qha_cordic_pipe.sv -----
// ============================================================================
// qha_cordic_pipe
// Vectoring CORDIC, one register stage per rotation step.
// ============================================================================
module qha_cordic_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  qha_pkg::t_tag        i_tag,
    input  qha_pkg::t_cord       i_xr,
    input  qha_pkg::t_cord       i_yr,
    output logic                 o_valid,
    output qha_pkg::t_tag        o_tag,
    output qha_pkg::t_angle      o_z
);

    localparam int N = qha_pkg::CORDIC_STEPS;

    qha_pkg::t_cord  w_x   [N+1];
    qha_pkg::t_cord  w_y   [N+1];
    qha_pkg::t_angle w_z   [N+1];
    logic            w_v   [N+1];
    qha_pkg::t_tag   w_tag [N+1];

    assign w_x[0]   = i_xr;
    assign w_y[0]   = i_yr;
    assign w_z[0]   = '0;
    assign w_v[0]   = i_valid;
    assign w_tag[0] = i_tag;

    for (genvar k = 0; k < N; k++) begin : g_step
        qha_pkg::t_cord  r_x, n_x, r_y, n_y;
        qha_pkg::t_angle r_z, n_z;
        qha_pkg::t_tag   r_tag;
        logic            r_v;

        always_comb begin
            if (!w_y[k][qha_pkg::CORD_W-1]) begin
                n_x = w_x[k] + (w_y[k] >>> k);
                n_y = w_y[k] - (w_x[k] >>> k);
                n_z = w_z[k] + qha_pkg::ATAN_DEG_Q16[k];
            end else begin
                n_x = w_x[k] - (w_y[k] >>> k);
                n_y = w_y[k] + (w_x[k] >>> k);
                n_z = w_z[k] - qha_pkg::ATAN_DEG_Q16[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= w_v[k];
            end
            if (i_adv) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_z   <= n_z;
                r_tag <= w_tag[k];
            end
        end

        assign w_x[k+1]   = r_x;
        assign w_y[k+1]   = r_y;
        assign w_z[k+1]   = r_z;
        assign w_v[k+1]   = r_v;
        assign w_tag[k+1] = r_tag;
    end

    assign o_valid = w_v[N];
    assign o_tag   = w_tag[N];
    assign o_z     = w_z[N];

endmodule

// ----- src/quadrant_heading_angle.sv -----
// ============================================================================
// quadrant_heading_angle
// Heading of a signed 2D vector in degrees (8 fraction bits) by CORDIC.
// ============================================================================
//  channel  | dir | payload               | handshake
//  i_vec    | in  | vec_x, vec_y (s16)    | valid/ready
//  o_head   | out | heading_deg (u17)     | valid/ready
//
//  One transaction per cycle while the output is not stalled; the data pass
//  the input stage, one stage per CORDIC rotation and the output stage.
//  Reset clears all valid bits; payload registers are not reset.
//  A stalled output freezes every stage; i_vec.ready follows that freeze.
// ============================================================================
module quadrant_heading_angle (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qha_vec_if.sink      i_vec,
    qha_head_if.source   o_head
);

    logic                  w_adv;
    logic                  r_pre_valid;
    qha_pkg::t_tag         r_pre_tag;
    qha_pkg::t_cord        r_pre_xr;
    qha_pkg::t_cord        r_pre_yr;
    qha_pkg::t_tag         n_pre_tag;
    qha_pkg::t_mag         w_ax, w_ay;
    qha_pkg::t_mag         w_num, w_den;

    logic                  w_cv;
    qha_pkg::t_tag         w_ctag;
    qha_pkg::t_angle       w_cz;

    qha_pkg::t_angle       w_zc;
    qha_pkg::t_angle       w_zr;
    logic [qha_pkg::SUM_W-1:0]     w_sum;
    qha_pkg::t_heading     n_head;
    qha_pkg::t_heading     r_head;
    logic                  r_out_valid;

    assign w_adv       = !r_out_valid || o_head.ready;
    assign i_vec.ready = w_adv;

    assign w_ax = i_vec.vec_x[qha_pkg::COORD_WIDTH-1]
                ? qha_pkg::t_mag'(-(qha_pkg::MAG_W'(signed'(i_vec.vec_x))))
                : qha_pkg::t_mag'(i_vec.vec_x);
    assign w_ay = i_vec.vec_y[qha_pkg::COORD_WIDTH-1]
                ? qha_pkg::t_mag'(-(qha_pkg::MAG_W'(signed'(i_vec.vec_y))))
                : qha_pkg::t_mag'(i_vec.vec_y);

    always_comb begin
        logic sx, sy;
        sx = i_vec.vec_x[qha_pkg::COORD_WIDTH-1];
        sy = i_vec.vec_y[qha_pkg::COORD_WIDTH-1];
        n_pre_tag.axis = (i_vec.vec_x == '0) || (i_vec.vec_y == '0);
        if (sx == sy) begin
            w_num = w_ax;
            w_den = w_ay;
        end else begin
            w_num = w_ay;
            w_den = w_ax;
        end
        case ({sx, sy})
            2'b00:   n_pre_tag.quad = qha_pkg::QUAD_BASE_270;
            2'b10:   n_pre_tag.quad = qha_pkg::QUAD_BASE_180;
            2'b11:   n_pre_tag.quad = qha_pkg::QUAD_BASE_90;
            default: n_pre_tag.quad = qha_pkg::QUAD_BASE_0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (w_adv) begin
            r_pre_valid <= i_vec.valid;
        end
        if (w_adv) begin
            r_pre_tag <= n_pre_tag;
            r_pre_xr  <= qha_pkg::t_cord'({2'b00, w_den});
            r_pre_yr  <= qha_pkg::t_cord'({2'b00, w_num});
        end
    end

    qha_cordic_pipe u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_pre_valid),
        .i_tag   (r_pre_tag),
        .i_xr    (r_pre_xr),
        .i_yr    (r_pre_yr),
        .o_valid (w_cv),
        .o_tag   (w_ctag),
        .o_z     (w_cz)
    );

    assign w_zc  = w_cz[qha_pkg::Z_W-1] ? '0 : w_cz;
    assign w_zr  = qha_pkg::t_angle'(w_zc + qha_pkg::RND_HALF) >>> qha_pkg::RND_SH;
    assign w_sum = qha_pkg::SUM_W'(w_zr[qha_pkg::OUT_WIDTH-1:0])
                 + qha_pkg::SUM_W'(qha_pkg::quad_base(w_ctag.quad));

    always_comb begin
        if (w_ctag.axis) begin
            n_head = '0;
        end else if (w_sum > qha_pkg::SUM_W'(qha_pkg::LIMIT)) begin
            n_head = qha_pkg::LIMIT;
        end else begin
            n_head = w_sum[qha_pkg::OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_cv;
        end
        if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign o_head.valid       = r_out_valid;
    assign o_head.heading_deg = r_head;

`ifndef NO_ASSERTIONS
    a_head_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_head <= qha_pkg::LIMIT))
        else $error("heading above saturation limit");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_head.valid)
        else $error("output valid after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_head.ready) |=> ($stable(w_cz) && $stable(w_cv)))
        else $error("pipeline moved during stall");

    a_ready_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_head.ready) |-> !i_vec.ready)
        else $error("input taken while output stalled");
`endif

endmodule
